[design/array_linked_list_engine_top_macros.svh]
// Assertion macros for the linked list engine top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ARRAY_LINKED_LIST_ENGINE_TOP_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ALLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/alle_pkg.sv]
// Shared constants, status codes and controller/datapath structs for the
// linked list engine. No dependencies.
`timescale 1ns / 1ps

package alle_pkg;

    // Default sizes
    localparam int unsigned SLOTS_DEF    = 16;
    localparam int unsigned KEY_BITS_DEF = 16;

    // Port field widths
    localparam int unsigned KEY_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned HEAD_W   = 5;
    localparam int unsigned USED_W   = 5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load;        // capture key, clear counter
        logic                cnt_clr;
        logic                cnt_inc;
        logic                slot_take;   // latch free slot from the pool
        logic                walk_start;  // cursor to head
        logic                walk_adv;    // cursor to next link
        logic                link_save;   // latch neighbors of found node
        logic                ins_link;    // write new node, claim pool entry
        logic                ins_tail;    // hook new node after tail
        logic                rem_unlink;  // bridge neighbors of removed node
        logic                rem_clear;   // null links of removed node
        logic                pool_put;    // return slot to pool
        logic                fin;         // present result
        logic [STATUS_W-1:0] fin_status;
    } alle_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic occ;        // pool entry at counter holds a slot
        logic cnt_last;   // counter at SLOTS-1
        logic cnt_end;    // counter at SLOTS
        logic head_null;
        logic t_null;     // cursor is null
        logic link_null;  // next link of cursor is null
        logic key_match;  // key at cursor equals search key
    } alle_sts_t;

endpackage

[design/alle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module alle_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/alle_ctrl.sv]
// Operation sequencer for the linked list engine: pool scans, list walks
// and link updates. Depends on alle_pkg.
`timescale 1ns / 1ps

module alle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    output logic                 busy,
    output alle_pkg::alle_cmd_t  cmd,
    input  alle_pkg::alle_sts_t  sts
);

    import alle_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_I_SCAN   = 4'd1;
    localparam logic [3:0] S_I_POOL   = 4'd2;
    localparam logic [3:0] S_I_WALK   = 4'd3;
    localparam logic [3:0] S_I_LINK   = 4'd4;
    localparam logic [3:0] S_I_TAIL   = 4'd5;
    localparam logic [3:0] S_R_WALK   = 4'd6;
    localparam logic [3:0] S_R_UNLINK = 4'd7;
    localparam logic [3:0] S_R_CLEAR  = 4'd8;
    localparam logic [3:0] S_R_SCAN   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (kind == KIND_REMOVE)
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_R_WALK;
                    end
                    else
                    begin
                        state_next = S_I_SCAN;
                    end
                end
            end
            S_I_SCAN:
            begin
                if (sts.occ)
                begin
                    state_next = S_I_POOL;
                end
                else if (sts.cnt_last)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            S_I_POOL:
            begin
                cmd.slot_take = 1'b1;
                if (sts.head_null)
                begin
                    state_next = S_I_LINK;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    cmd.cnt_clr    = 1'b1;
                    state_next     = S_I_WALK;
                end
            end
            S_I_WALK:
            begin
                if (!sts.link_null && !sts.cnt_end)
                begin
                    cmd.walk_adv = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                end
                else
                begin
                    state_next = S_I_LINK;
                end
            end
            S_I_LINK:
            begin
                cmd.ins_link = 1'b1;
                if (sts.head_null)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_DONE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_I_TAIL;
                end
            end
            S_I_TAIL:
            begin
                cmd.ins_tail   = 1'b1;
                cmd.fin        = 1'b1;
                cmd.fin_status = ST_DONE;
                state_next     = S_IDLE;
            end
            S_R_WALK:
            begin
                if (sts.t_null)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else if (sts.key_match)
                begin
                    cmd.link_save = 1'b1;
                    state_next    = S_R_UNLINK;
                end
                else if (sts.cnt_last)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                end
            end
            S_R_UNLINK:
            begin
                cmd.rem_unlink = 1'b1;
                state_next     = S_R_CLEAR;
            end
            S_R_CLEAR:
            begin
                cmd.rem_clear = 1'b1;
                cmd.cnt_clr   = 1'b1;
                state_next    = S_R_SCAN;
            end
            S_R_SCAN:
            begin
                if (!sts.occ)
                begin
                    cmd.pool_put   = 1'b1;
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_DONE;
                    state_next     = S_IDLE;
                end
                else if (sts.cnt_last)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_DONE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[design/alle_dp.sv]
// Datapath of the linked list engine: key, link and pool memories with
// valid bits, cursor, counter, head, fill count and result registers.
// Depends on alle_pkg and alle_ram.
`timescale 1ns / 1ps

module alle_dp #(
    parameter int unsigned SLOTS    = alle_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BITS = alle_pkg::KEY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [alle_pkg::KEY_W-1:0]     key_value,
    input  logic                           kind,
    input  alle_pkg::alle_cmd_t            cmd,
    output alle_pkg::alle_sts_t            sts,
    output logic                           done,
    output logic [alle_pkg::STATUS_W-1:0]  status,
    output logic [alle_pkg::SLOT_W-1:0]    slot,
    output logic [alle_pkg::HEAD_W-1:0]    list_head,
    output logic [alle_pkg::USED_W-1:0]    entries_used
);

    import alle_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned TW = $clog2(SLOTS + 1);
    localparam logic [TW-1:0] NIL = TW'(SLOTS);

    // Operation and walk state
    logic                kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TW-1:0]       cnt_reg, cnt_next;
    logic [TW-1:0]       t_reg, t_next;
    logic [AW-1:0]       s_reg;
    logic [AW-1:0]       idx_reg;
    logic [TW-1:0]       nx_reg;
    logic [TW-1:0]       pv_reg;
    logic [TW-1:0]       head_reg;
    logic [TW-1:0]       used_reg;

    // Per-entry valid bits
    logic [SLOTS-1:0]    occ_reg;   // pool entry holds a slot
    logic [SLOTS-1:0]    wrt_reg;   // pool entry written since reset
    logic [SLOTS-1:0]    nvld_reg;  // next link written
    logic [SLOTS-1:0]    pvld_reg;  // prev link written
    logic                nrvld_reg;
    logic                prvld_reg;
    logic                wrt_q_reg;

    // Result registers
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [AW-1:0]       slot_reg;

    // Memory ports
    logic [AW-1:0]       t_addr;
    logic [AW-1:0]       cnt_addr;
    logic [KEY_BITS-1:0] key_rdata;
    logic [TW-1:0]       next_rdata;
    logic [TW-1:0]       prev_rdata;
    logic [AW-1:0]       pool_rdata;
    logic                n_we;
    logic [AW-1:0]       n_wa;
    logic [TW-1:0]       n_wd;
    logic                p_we;
    logic [AW-1:0]       p_wa;
    logic [TW-1:0]       p_wd;
    logic [TW-1:0]       link_data;
    logic [TW-1:0]       prev_data;
    logic                head_null;
    logic                pv_in;
    logic                nx_in;

    assign t_addr    = t_next[AW-1:0];
    assign cnt_addr  = cnt_reg[AW-1:0];
    assign link_data = nrvld_reg ? next_rdata : NIL;
    assign prev_data = prvld_reg ? prev_rdata : NIL;
    assign head_null = (head_reg >= NIL);
    assign pv_in     = (pv_reg < NIL);
    assign nx_in     = (nx_reg < NIL);

    // Cursor: the link memories are always read at the next cursor
    always_comb
    begin
        t_next = t_reg;
        if (cmd.walk_start)
        begin
            t_next = head_reg;
        end
        else if (cmd.walk_adv)
        begin
            t_next = link_data;
        end
    end

    // Counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load || cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + TW'(1);
        end
    end

    // Next link write port
    always_comb
    begin
        n_we = 1'b0;
        n_wa = s_reg;
        n_wd = NIL;
        if (cmd.ins_link)
        begin
            n_we = 1'b1;
        end
        else if (cmd.ins_tail)
        begin
            n_we = 1'b1;
            n_wa = t_reg[AW-1:0];
            n_wd = TW'(s_reg);
        end
        else if (cmd.rem_unlink && pv_in)
        begin
            n_we = 1'b1;
            n_wa = pv_reg[AW-1:0];
            n_wd = nx_reg;
        end
        else if (cmd.rem_clear)
        begin
            n_we = 1'b1;
            n_wa = t_reg[AW-1:0];
        end
    end

    // Prev link write port
    always_comb
    begin
        p_we = 1'b0;
        p_wa = s_reg;
        p_wd = NIL;
        if (cmd.ins_link)
        begin
            p_we = 1'b1;
            p_wd = head_null ? NIL : t_reg;
        end
        else if (cmd.rem_unlink && nx_in)
        begin
            p_we = 1'b1;
            p_wa = nx_reg[AW-1:0];
            p_wd = pv_reg;
        end
        else if (cmd.rem_clear)
        begin
            p_we = 1'b1;
            p_wa = t_reg[AW-1:0];
        end
    end

    alle_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.ins_link),
        .waddr (s_reg),
        .wdata (key_reg),
        .raddr (t_addr),
        .rdata (key_rdata)
    );

    alle_ram #(
        .WIDTH (TW),
        .DEPTH (SLOTS)
    ) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_wa),
        .wdata (n_wd),
        .raddr (t_addr),
        .rdata (next_rdata)
    );

    alle_ram #(
        .WIDTH (TW),
        .DEPTH (SLOTS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_wa),
        .wdata (p_wd),
        .raddr (t_addr),
        .rdata (prev_rdata)
    );

    alle_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_pool_ram (
        .clk   (clk),
        .we    (cmd.pool_put),
        .waddr (cnt_addr),
        .wdata (t_reg[AW-1:0]),
        .raddr (cnt_addr),
        .rdata (pool_rdata)
    );

    // Control registers: valid bits, head, fill count, cursor, counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '1;
            wrt_reg   <= '0;
            nvld_reg  <= '0;
            pvld_reg  <= '0;
            nrvld_reg <= 1'b0;
            prvld_reg <= 1'b0;
            wrt_q_reg <= 1'b0;
            head_reg  <= NIL;
            used_reg  <= '0;
            cnt_reg   <= '0;
            t_reg     <= NIL;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            t_reg     <= t_next;
            done_reg  <= cmd.fin;
            nrvld_reg <= (t_next < NIL) && nvld_reg[t_addr];
            prvld_reg <= (t_next < NIL) && pvld_reg[t_addr];
            wrt_q_reg <= wrt_reg[cnt_addr];
            if (n_we)
            begin
                nvld_reg[n_wa] <= 1'b1;
            end
            if (p_we)
            begin
                pvld_reg[p_wa] <= 1'b1;
            end
            // Claim the pool entry and count the new node
            if (cmd.ins_link)
            begin
                occ_reg[idx_reg] <= 1'b0;
                if (head_null)
                begin
                    head_reg <= TW'(s_reg);
                end
                if (used_reg < NIL)
                begin
                    used_reg <= used_reg + TW'(1);
                end
            end
            // Removing the head moves it to the next node
            if (cmd.rem_unlink && !pv_in)
            begin
                head_reg <= nx_reg;
            end
            if (cmd.rem_clear && (used_reg != '0))
            begin
                used_reg <= used_reg - TW'(1);
            end
            // Return the slot to the first empty pool entry
            if (cmd.pool_put)
            begin
                occ_reg[cnt_addr] <= 1'b1;
                wrt_reg[cnt_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= KEY_BITS'(key_value);
        end
        if (cmd.slot_take)
        begin
            s_reg   <= wrt_q_reg ? pool_rdata : cnt_addr;
            idx_reg <= cnt_addr;
        end
        if (cmd.link_save)
        begin
            nx_reg <= link_data;
            pv_reg <= prev_data;
        end
        if (cmd.fin)
        begin
            status_reg <= cmd.fin_status;
            if (cmd.fin_status == ST_DONE)
            begin
                slot_reg <= (kind_reg == KIND_REMOVE) ? t_reg[AW-1:0] : s_reg;
            end
            else
            begin
                slot_reg <= '0;
            end
        end
    end

    // Status to controller
    always_comb
    begin
        sts           = '0;
        sts.occ       = occ_reg[cnt_addr];
        sts.cnt_last  = (cnt_reg == TW'(SLOTS - 1));
        sts.cnt_end   = (cnt_reg == NIL);
        sts.head_null = head_null;
        sts.t_null    = (t_reg >= NIL);
        sts.link_null = (link_data >= NIL);
        sts.key_match = (key_rdata == key_reg);
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = SLOT_W'(slot_reg);
    assign list_head    = HEAD_W'(head_reg);
    assign entries_used = USED_W'(used_reg);

endmodule

[design/array_linked_list_engine_top.sv]
// Channel   Handshake              Fields
// command   start, busy            kind, key_value
// result    done (one-cycle pulse) status, slot, list_head, entries_used
//
// A command transfers when start is high and busy is low. Insert scans the pool
// one entry per cycle for the first occupied entry and, unless the list is empty,
// walks the list one node per cycle over the link memory read port to the tail;
// remove walks one node per cycle to the match, then scans the pool one entry per
// cycle for the first empty entry. Insert into a full list and remove of a missing
// key finish with a failure status. Reset leaves an empty list with every slot free,
// at once, with no clearing pass. Results cannot be stalled.
//
// Top level of the linked list engine. Depends on alle_pkg, alle_ctrl, alle_dp
// and the assertion macro header.
`timescale 1ns / 1ps
`include "array_linked_list_engine_top_macros.svh"

module array_linked_list_engine_top #(
    parameter int unsigned SLOTS    = alle_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BITS = alle_pkg::KEY_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [alle_pkg::KEY_W-1:0]     key_value,
    output logic                           done,
    output logic [alle_pkg::STATUS_W-1:0]  status,
    output logic [alle_pkg::SLOT_W-1:0]    slot,
    output logic [alle_pkg::HEAD_W-1:0]    list_head,
    output logic [alle_pkg::USED_W-1:0]    entries_used
);

    import alle_pkg::*;

    alle_cmd_t cmd;
    alle_sts_t sts;

    alle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    alle_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_value    (key_value),
        .kind         (kind),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .list_head    (list_head),
        .entries_used (entries_used)
    );

    // Checks
    `ALLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not go busy")
    `ALLE_ASSERT_NOW(a_done_idle, done, !busy, "result presented while busy")
    `ALLE_ASSERT_NOW(a_fail_slot, done && (status != ST_DONE), slot == '0, "failed op has slot")
    `ALLE_ASSERT_NOW(a_fin_once, cmd.fin, busy && !done, "finish issued outside an operation")

endmodule
